### rtl/mcg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sine table generator for the metronome
// click generator. Depends on nothing else.
package mcg_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SAMPLES_PER_BEAT    = 3'd0;
  localparam logic [2:0] CFG_CLICK_LENGTH        = 3'd1;
  localparam logic [2:0] CFG_BAR_COUNT           = 3'd2;
  localparam logic [2:0] CFG_CHANNEL_COUNT       = 3'd3;
  localparam logic [2:0] CFG_GAIN                = 3'd4;
  localparam logic [2:0] CFG_TONE_PHASE_STEP     = 3'd5;
  localparam logic [2:0] CFG_ENVELOPE_PHASE_STEP = 3'd6;

  // Register values after reset.
  localparam logic [23:0] RST_SAMPLES_PER_BEAT    = 24'd22050;
  localparam logic [23:0] RST_CLICK_LENGTH        = 24'd2205;
  localparam logic [15:0] RST_BAR_COUNT           = 16'd4;
  localparam logic [3:0]  RST_CHANNEL_COUNT       = 4'd2;
  localparam logic [16:0] RST_GAIN                = 17'd16384;
  localparam logic [31:0] RST_TONE_PHASE_STEP     = 32'd97391549;
  localparam logic [31:0] RST_ENVELOPE_PHASE_STEP = 32'd973915;

  // Arithmetic constants.
  localparam logic [14:0] FULL_SCALE  = 15'd32767;
  localparam logic [50:0] ROUND_HALF  = 51'(32767) << 18;    // half of 32767 * 2^19
  localparam logic [31:0] SAT_LIMIT   = 32'd1073676289;      // 32767 * 32767
  localparam logic [31:0] PHASE_QUART = 32'h4000_0000;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_CHECK  = 11'b000_0000_0010,
    ST_LOOK_S = 11'b000_0000_0100,
    ST_LOOK_C = 11'b000_0000_1000,
    ST_ENV    = 11'b000_0001_0000,
    ST_MUL1   = 11'b000_0010_0000,
    ST_MUL2   = 11'b000_0100_0000,
    ST_ROUND  = 11'b000_1000_0000,
    ST_DIV    = 11'b001_0000_0000,
    ST_APPLY  = 11'b010_0000_0000,
    ST_EMIT   = 11'b100_0000_0000
  } mcg_state_t;

  // One quarter-wave table entry: 32767*sin(pi/2*k/Q) from a six-term
  // integer series on a Q2.30 argument, rounded half up and clamped.
  function automatic logic [14:0] table_entry(input int k, input int table_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    longint unsigned v;
    x   = (64'd1686629713 * longint'(k)) >> (table_bits - 2);
    x2  = (x * x) >> 30;
    sum = longint'(x);
    t   = ((x * x2) >> 30) / 6;
    sum = sum - longint'(t);
    t   = ((t * x2) >> 30) / 20;
    sum = sum + longint'(t);
    t   = ((t * x2) >> 30) / 42;
    sum = sum - longint'(t);
    t   = ((t * x2) >> 30) / 72;
    sum = sum + longint'(t);
    t   = ((t * x2) >> 30) / 110;
    sum = sum - longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return v[14:0];
  endfunction

endpackage

### rtl/metronome_click_generator.sv
`timescale 1ns / 1ps
// Metronome click generator: register file, sequencer and shared datapath.
// Depends on mcg_pkg.

// Each input word renders one audio frame and yields one output word per
// channel. A frame inside the click burst goes through two quarter-wave
// table reads, two passes through one shared multiplier, rounding and a
// division by 32767 done as a single shift and add; a frame whose sample
// saturates skips the division. Each channel word is then held for as long
// as the output is stalled. A silent frame goes straight to its channel
// words, and a word after the render has finished yields nothing. The block
// takes no new input word until the last channel word of the frame has been
// taken. The configuration port is always ready and should be written only
// while idle.
module metronome_click_generator
  import mcg_pkg::*;
#(
  parameter int MAX_CHANNELS    = 8,
  parameter int SINE_TABLE_BITS = 10,
  parameter int BEATS_PER_BAR   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic [2:0]         out_channel,
  output logic               out_frame_last,
  output logic               out_render_last,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int ADDR_W  = SINE_TABLE_BITS - 1;
  localparam int BIB_W   = (BEATS_PER_BAR > 1) ? $clog2(BEATS_PER_BAR) : 1;
  localparam int TOT_W   = (16 + $clog2(BEATS_PER_BAR) > 19) ?
                           16 + $clog2(BEATS_PER_BAR) : 19;

  // Configuration registers.
  logic [23:0] spb_r;
  logic [23:0] click_r;
  logic [15:0] bars_r;
  logic [3:0]  chcount_r;
  logic [16:0] gain_r;
  logic [31:0] tone_step_r;
  logic [31:0] env_step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r       <= RST_SAMPLES_PER_BEAT;
      click_r     <= RST_CLICK_LENGTH;
      bars_r      <= RST_BAR_COUNT;
      chcount_r   <= RST_CHANNEL_COUNT;
      gain_r      <= RST_GAIN;
      tone_step_r <= RST_TONE_PHASE_STEP;
      env_step_r  <= RST_ENVELOPE_PHASE_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLES_PER_BEAT:    spb_r       <= cfg_data[23:0];
        CFG_CLICK_LENGTH:        click_r     <= cfg_data[23:0];
        CFG_BAR_COUNT:           bars_r      <= cfg_data[15:0];
        CFG_CHANNEL_COUNT:       chcount_r   <= cfg_data[3:0];
        CFG_GAIN:                gain_r      <= cfg_data[16:0];
        CFG_TONE_PHASE_STEP:     tone_step_r <= cfg_data;
        CFG_ENVELOPE_PHASE_STEP: env_step_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective settings: zero counts act as one, channels clamp at the maximum.
  logic [23:0]      spb_eff;
  logic [23:0]      click_eff;
  logic [15:0]      bars_eff;
  logic [3:0]       ch_one;
  logic [3:0]       chans_eff;
  logic [TOT_W-1:0] beat_total;

  always_comb begin
    spb_eff    = (spb_r == 24'd0) ? 24'd1 : spb_r;
    click_eff  = (click_r == 24'd0) ? 24'd1 : click_r;
    bars_eff   = (bars_r == 16'd0) ? 16'd1 : bars_r;
    ch_one     = (chcount_r == 4'd0) ? 4'd1 : chcount_r;
    chans_eff  = (5'(ch_one) > 5'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : ch_one;
    beat_total = TOT_W'(bars_eff) * TOT_W'(BEATS_PER_BAR);
  end

  // Quarter-wave sine table, fixed at elaboration.
  logic [14:0] sine_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign sine_rom[k] = table_entry(k, SINE_TABLE_BITS);
  end

  // Render state.
  mcg_state_t        state_r, state_nxt;
  logic [23:0]       frame_r;
  logic [17:0]       beat_r;
  logic [BIB_W-1:0]  bib_r;
  logic [31:0]       tone_ph_r;
  logic [31:0]       env_ph_r;
  logic              finished_r;
  logic              beat_end_r;
  logic              last_r;
  logic [3:0]        ch_r;

  // Datapath registers.
  logic [14:0]        tab_v_r;
  logic               tab_neg_r;
  logic [14:0]        mag_r;
  logic               sneg_r;
  logic [15:0]        env_r;
  logic [18:0]        gacc_r;
  logic [49:0]        prod_r;
  logic [29:0]        rem_r;
  logic [14:0]        quo_r;
  logic signed [15:0] value_r;

  // Shared table read port: tone phase, or envelope phase shifted to a cosine.
  logic [31:0]                look_ph;
  logic [SINE_TABLE_BITS-1:0] look_idx;
  logic [SINE_TABLE_BITS-3:0] look_pos;
  logic [ADDR_W-1:0]          look_addr;

  always_comb begin
    look_ph  = (state_r == ST_LOOK_S) ? tone_ph_r : env_ph_r + PHASE_QUART;
    look_idx = look_ph[31 -: SINE_TABLE_BITS];
    look_pos = look_idx[SINE_TABLE_BITS-3:0];
    if (look_idx[SINE_TABLE_BITS-2]) begin
      look_addr = ADDR_W'(QUARTER) - {1'b0, look_pos};
    end else begin
      look_addr = {1'b0, look_pos};
    end
  end

  // Shared multiplier.
  logic [30:0] mul_a;
  logic [18:0] mul_b;
  logic [49:0] mul_p;

  always_comb begin
    if (state_r == ST_MUL1) begin
      mul_a = {16'd0, mag_r};
      mul_b = {3'd0, env_r};
    end else begin
      mul_a = prod_r[30:0];
      mul_b = gacc_r;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Rounding to nearest before the division by 32767.
  logic [50:0] round_sum;
  logic [31:0] round_t;

  assign round_sum = {1'b0, prod_r} + ROUND_HALF;
  assign round_t   = round_sum[50:19];

  // Beat and render end tests for the current frame.
  logic beat_end_c;
  logic last_c;
  logic frame_done;

  always_comb begin
    beat_end_c = (25'(frame_r) + 25'd1) >= 25'(spb_eff);
    last_c     = beat_end_c &&
                 ((TOT_W'(beat_r) + TOT_W'(1)) >= beat_total);
    frame_done = (state_r == ST_EMIT) && !out_stall &&
                 ((ch_r + 4'd1) == chans_eff);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (finished_r || (TOT_W'(beat_r) >= beat_total)) begin
          state_nxt = ST_IDLE;
        end else if (frame_r < click_eff) begin
          state_nxt = ST_LOOK_S;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_LOOK_S: state_nxt = ST_LOOK_C;
      ST_LOOK_C: state_nxt = ST_ENV;
      ST_ENV:    state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_ROUND;
      ST_ROUND: begin
        state_nxt = (round_t >= SAT_LIMIT) ? ST_APPLY : ST_DIV;
      end
      ST_DIV:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (frame_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Render position, phases and channel counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r    <= 24'd0;
      beat_r     <= 18'd0;
      bib_r      <= '0;
      tone_ph_r  <= 32'd0;
      env_ph_r   <= 32'd0;
      finished_r <= 1'b0;
      beat_end_r <= 1'b0;
      last_r     <= 1'b0;
      ch_r       <= 4'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_restart) begin
            frame_r    <= 24'd0;
            beat_r     <= 18'd0;
            bib_r      <= '0;
            tone_ph_r  <= 32'd0;
            env_ph_r   <= 32'd0;
            finished_r <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (finished_r || (TOT_W'(beat_r) >= beat_total)) begin
            finished_r <= 1'b1;
          end
          beat_end_r <= beat_end_c;
          last_r     <= last_c;
          ch_r       <= 4'd0;
        end
        ST_EMIT: begin
          if (frame_done) begin
            if (beat_end_r) begin
              frame_r   <= 24'd0;
              beat_r    <= beat_r + 18'd1;
              tone_ph_r <= 32'd0;
              env_ph_r  <= 32'd0;
              // The beat-in-bar count follows the 18-bit beat index, wrap included.
              if ((beat_r == '1) || (32'(bib_r) == BEATS_PER_BAR - 1)) begin
                bib_r <= '0;
              end else begin
                bib_r <= bib_r + BIB_W'(1);
              end
              if (last_r) finished_r <= 1'b1;
            end else begin
              frame_r   <= frame_r + 24'd1;
              tone_ph_r <= tone_ph_r + tone_step_r;
              env_ph_r  <= env_ph_r + env_step_r;
            end
          end else if (!out_stall) begin
            ch_r <= ch_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Arithmetic datapath, one step per state.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_CHECK: begin
        value_r <= 16'sd0;
      end
      ST_LOOK_S, ST_LOOK_C: begin
        tab_v_r   <= sine_rom[look_addr];
        tab_neg_r <= look_idx[SINE_TABLE_BITS-1];
        mag_r     <= tab_v_r;
        sneg_r    <= tab_neg_r;
      end
      ST_ENV: begin
        // 32767 minus the signed cosine value.
        if (tab_neg_r) begin
          env_r <= {1'b0, FULL_SCALE} + {1'b0, tab_v_r};
        end else begin
          env_r <= {1'b0, FULL_SCALE} - {1'b0, tab_v_r};
        end
        // Gain times accent: four on the bar's first beat, three otherwise.
        if (bib_r == '0) begin
          gacc_r <= {gain_r, 2'b00};
        end else begin
          gacc_r <= {2'b00, gain_r} + {1'b0, gain_r, 1'b0};
        end
      end
      ST_MUL1, ST_MUL2: begin
        prod_r <= mul_p;
      end
      ST_ROUND: begin
        rem_r <= round_t[29:0];
        quo_r <= FULL_SCALE;
      end
      ST_DIV: begin
        // Division by 2^15 - 1: for any value below 32767 squared the
        // quotient is (t + (t >> 15) + 1) >> 15.
        quo_r <= 15'((rem_r + 30'(rem_r[29:15]) + 30'd1) >> 15);
      end
      ST_APPLY: begin
        value_r <= sneg_r ? (16'sd0 - $signed({1'b0, quo_r})) : $signed({1'b0, quo_r});
      end
      default: ;
    endcase
  end

  // Ports.
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_EMIT);
  assign out_sample      = value_r;
  assign out_channel     = ch_r[2:0];
  assign out_frame_last  = (ch_r + 4'd1) == chans_eff;
  assign out_render_last = last_r;

`ifndef SYNTH
  // A result word is never shown while a new input word could be taken.
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result word offered while input is open");

  // The sample saturates symmetrically and never reaches the negative limit.
  a_no_neg_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample != 16'sh8000))
    else $error("sample outside the symmetric range");

  // Channel words of a frame come in order with no gap.
  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_frame_last) |=>
      (out_valid && (out_channel == $past(out_channel) + 3'd1)))
    else $error("channel sequence broken");

  // After the frame's last channel word the block returns to idle.
  a_frame_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_frame_last) |=> (!out_valid && !in_stall))
    else $error("block not idle after last channel word");
`endif

endmodule

### tb/sv/click_checker.sv
`timescale 1ns / 1ps
// Checker for the metronome click generator: watches the input, result and
// configuration channels, predicts every PCM word and compares it with the
// block's output. Depends on mcg_pkg.
module click_checker
  import mcg_pkg::*;
#(
  parameter int MAX_CHANNELS    = 8,
  parameter int SINE_TABLE_BITS = 10,
  parameter int BEATS_PER_BAR   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_restart,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_sample,
  input  logic [2:0]         out_channel,
  input  logic               out_frame_last,
  input  logic               out_render_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fault_count,
  output int                 words_owed
);

  localparam int     QUARTER     = 1 << (SINE_TABLE_BITS - 2);
  localparam longint PCM_DIVISOR = 64'sd2 * 64'sd32767 * 64'sd65536 * 64'sd4;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         channel;
    logic               frame_last;
    logic               render_last;
  } pcm_word_t;

  // Quarter-wave sine table, filled once at start-up.
  logic [14:0] sine_quarter [0:QUARTER];

  // Register copies.
  logic [23:0] beat_len;
  logic [23:0] click_len;
  logic [15:0] bars;
  logic [3:0]  chans;
  logic [16:0] gain_q16;
  logic [31:0] tone_step;
  logic [31:0] env_step;

  // Render position.
  logic [23:0] frame_pos;
  logic [17:0] beat_no;
  logic [31:0] tone_ph;
  logic [31:0] env_ph;
  logic        done;

  // PCM words predicted but not yet seen on the result channel.
  pcm_word_t   pcm_due [$];

  // One table point: 32767*sin(pi/2*k/Q) from a six-term series on a Q2.30
  // argument, rounded half up and clamped to full scale.
  function automatic logic [14:0] quarter_point(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint          acc;
    longint          v;
    int              i;
    x    = (64'd1686629713 * 64'(unsigned'(k))) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    acc  = 0;
    n    = 1;
    for (i = 0; i < 6; i++) begin
      if (i % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
      term = ((term * x2) >> 30) / ((n + 1) * (n + 2));
      n    = n + 2;
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc * 64'sd32767 + 64'sd536870912) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return v[14:0];
  endfunction

  // Signed sine of a 32-bit phase from the top table bits, no interpolation.
  function automatic int sine_at(input logic [31:0] ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    int                         pos;
    int                         v;
    idx  = ph[31 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    pos  = int'(idx[SINE_TABLE_BITS-3:0]);
    if (quad[0]) begin
      pos = QUARTER - pos;
    end
    v = int'(sine_quarter[pos]);
    return quad[1] ? -v : v;
  endfunction

  initial begin : build_table
    int k;
    fault_count = 0;
    words_owed  = 0;
    for (k = 0; k <= QUARTER; k++) begin
      sine_quarter[k] = quarter_point(k);
    end
  end

  always @(posedge clk) begin : predict_and_compare
    int        eff_len;
    int        eff_click;
    int        beats_total;
    int        n_ch;
    int        s;
    int        c;
    int        mag;
    int        level;
    int        ch;
    longint    prod;
    longint    rounded;
    bit        beat_over;
    bit        closing;
    pcm_word_t want;
    pcm_word_t word;
    if (!rst_n) begin
      beat_len  = RST_SAMPLES_PER_BEAT;
      click_len = RST_CLICK_LENGTH;
      bars      = RST_BAR_COUNT;
      chans     = RST_CHANNEL_COUNT;
      gain_q16  = RST_GAIN;
      tone_step = RST_TONE_PHASE_STEP;
      env_step  = RST_ENVELOPE_PHASE_STEP;
      frame_pos = '0;
      beat_no   = '0;
      tone_ph   = '0;
      env_ph    = '0;
      done      = 1'b0;
      pcm_due.delete();
    end else begin
      // Compare each PCM word taken from the block with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (pcm_due.size() == 0) begin
          $error("unexpected word: sample %0d channel %0d", out_sample, out_channel);
          fault_count++;
        end else begin
          want = pcm_due.pop_front();
          if (out_sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, out_sample);
            fault_count++;
          end
          if (out_channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, out_channel);
            fault_count++;
          end
          if (out_frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, out_frame_last);
            fault_count++;
          end
          if (out_render_last !== want.render_last) begin
            $error("render_last: expected %0d, got %0d", want.render_last,
                   out_render_last);
            fault_count++;
          end
        end
      end

      // Register writes; unknown indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLES_PER_BEAT:    beat_len  = cfg_data[23:0];
          CFG_CLICK_LENGTH:        click_len = cfg_data[23:0];
          CFG_BAR_COUNT:           bars      = cfg_data[15:0];
          CFG_CHANNEL_COUNT:       chans     = cfg_data[3:0];
          CFG_GAIN:                gain_q16  = cfg_data[16:0];
          CFG_TONE_PHASE_STEP:     tone_step = cfg_data;
          CFG_ENVELOPE_PHASE_STEP: env_step  = cfg_data;
          default: ;
        endcase
      end

      // Render one frame for every input word accepted while the render is not finished.
      if (in_valid && !in_stall) begin
        if (in_restart) begin
          frame_pos = '0;
          beat_no   = '0;
          tone_ph   = '0;
          env_ph    = '0;
          done      = 1'b0;
        end
        eff_len     = (beat_len == 0) ? 1 : int'(beat_len);
        eff_click   = (click_len == 0) ? 1 : int'(click_len);
        beats_total = ((bars == 0) ? 1 : int'(bars)) * BEATS_PER_BAR;
        n_ch        = (chans == 0) ? 1 : int'(chans);
        if (n_ch > MAX_CHANNELS) begin
          n_ch = MAX_CHANNELS;
        end
        if (done || int'(beat_no) >= beats_total) begin
          done = 1'b1;
        end else begin
          level = 0;
          // Sine burst shaped by the raised cosine, gain and accent.
          if (int'(frame_pos) < eff_click) begin
            s    = sine_at(tone_ph);
            c    = sine_at(env_ph + PHASE_QUART);
            mag  = (s < 0) ? -s : s;
            prod = longint'(mag) * longint'(32767 - c) * longint'(gain_q16)
                   * ((int'(beat_no) % BEATS_PER_BAR == 0) ? 64'sd4 : 64'sd3);
            rounded = (prod + PCM_DIVISOR / 2) / PCM_DIVISOR;
            if (rounded > 32767) begin
              rounded = 32767;
            end
            level = (s < 0) ? -int'(rounded) : int'(rounded);
          end
          beat_over = (int'(frame_pos) + 1 >= eff_len);
          closing   = beat_over && (int'(beat_no) + 1 >= beats_total);
          for (ch = 0; ch < n_ch; ch++) begin
            word.sample      = 16'(level);
            word.channel     = 3'(ch);
            word.frame_last  = (ch + 1 == n_ch);
            word.render_last = closing;
            pcm_due.push_back(word);
          end
          // Advance the render position.
          if (beat_over) begin
            frame_pos = '0;
            beat_no   = beat_no + 1'b1;
            tone_ph   = '0;
            env_ph    = '0;
            if (closing) begin
              done = 1'b1;
            end
          end else begin
            frame_pos = frame_pos + 1'b1;
            tone_ph   = tone_ph + tone_step;
            env_ph    = env_ph + env_step;
          end
        end
      end
    end
    words_owed = pcm_due.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the metronome click generator: clock, reset, stimulus
// and verdict. Depends on mcg_pkg, metronome_click_generator and click_checker.
module tb_top;
  import mcg_pkg::*;

  localparam int          MAX_CHANNELS     = 8;
  localparam int          SINE_TABLE_BITS  = 10;
  localparam int          BEATS_PER_BAR    = 4;
  localparam int          SETTLE_CYCLES    = 40;
  localparam int          RANDOM_WORDS     = 150;
  localparam int          LONG_HOLD_AT     = 300;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam logic [2:0]  CFG_UNUSED       = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_restart;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_sample;
  logic [2:0]         out_channel;
  logic               out_frame_last;
  logic               out_render_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 fault_count;
  int                 words_owed;
  bit                 tx_idle;

  metronome_click_generator #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .BEATS_PER_BAR   (BEATS_PER_BAR)
  ) u_dut (.*);

  click_checker #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .BEATS_PER_BAR   (BEATS_PER_BAR)
  ) u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one input word after an optional gap and wait until it is taken.
  task automatic send_word(input logic restart_bit);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart_bit;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the input off until every predicted word has arrived; before a
  // register write also let a frame that yields nothing run out.
  task automatic settle(input bit before_write);
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_owed != 0) @(negedge clk);
    @(posedge clk);
    if (before_write) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // One register write; the valid is left high for a following write.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
    settle(1'b1);
    write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  // Write the whole register set, plus a word to the unused index.
  task automatic load_regs(input logic [23:0] spb, input logic [23:0] clen,
                           input logic [15:0] bar_n, input logic [3:0] ch_n,
                           input logic [16:0] gain_v, input logic [31:0] tone_v,
                           input logic [31:0] env_v);
    settle(1'b1);
    write_reg(CFG_SAMPLES_PER_BEAT, 32'(spb));
    write_reg(CFG_CLICK_LENGTH, 32'(clen));
    write_reg(CFG_BAR_COUNT, 32'(bar_n));
    write_reg(CFG_CHANNEL_COUNT, 32'(ch_n));
    write_reg(CFG_GAIN, 32'(gain_v));
    write_reg(CFG_TONE_PHASE_STEP, tone_v);
    write_reg(CFG_ENVELOPE_PHASE_STEP, env_v);
    write_reg(CFG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls per word, recurring stretches without any, and one
  // long hold-off that backs the block up into its input.
  initial begin : result_sink
    int taken;
    int hold;
    taken = 0;
    out_stall <= 1'b0;
    forever begin
      if (taken == LONG_HOLD_AT) begin
        hold = LONG_HOLD_CYCLES;
      end else if ((taken / 64) % 3 == 2) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 17);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [23:0] spb_w;
    logic [23:0] clk_w;
    logic [15:0] bar_w;
    logic [3:0]  ch_w;
    logic [16:0] gain_w;
    logic [31:0] env_w;
    int          clk_e;
    int          frames;
    int          pos;
    int          n;
    int          k;
    int          counted;
    int          phase;
    bit          r;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_SAMPLES_PER_BEAT;
    cfg_data   <= '0;
    tx_idle    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings after reset: the opening frames of the default render.
    repeat (3) send_word(1'b0);
    tx_idle = 1'b1;

    // Beat shorter than the click, nine channels clipped to eight, gain above
    // unity so the negative peaks saturate; the render then runs out and goes silent.
    load_regs(24'd2, 24'd6, 16'd1, 4'd9, 17'h1FFFF, 32'hC000_0000, 32'h8000_0000);
    send_word(1'b1);
    repeat (8) send_word(1'b0);

    // All-zero lengths and counts behave as one.
    load_regs(24'd0, 24'd0, 16'd0, 4'd0, 17'h10000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(1'b1);
    repeat (2) send_word(1'b0);

    // Longest beat and click, most bars, then the beat shortened mid-render.
    load_regs(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 4'd1, 17'd1, 32'h2000_0000, $urandom());
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    set_reg(CFG_SAMPLES_PER_BEAT, 32'd2);
    send_word(1'b0);

    // Bar count lowered below the beat already reached ends the render.
    set_reg(CFG_SAMPLES_PER_BEAT, 32'd1);
    repeat (4) send_word(1'b0);
    set_reg(CFG_BAR_COUNT, 32'd1);
    send_word(1'b0);
    send_word(1'b1);

    // Random renders: short beats, mostly whole renders, some restarts.
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_WORDS) begin
      spb_w = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom_range(1, 8));
      clk_w = 24'($urandom_range(0, int'(spb_w) + 3));
      bar_w = 16'($urandom_range(0, 2));
      ch_w  = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       gain_w = 17'($urandom_range(0, 17'h1FFFF));
        1:       gain_w = 17'h10000;
        2:       gain_w = 17'($urandom_range(1, 16'hFFFF));
        default: gain_w = 17'h1FFFF;
      endcase
      clk_e = (clk_w == 0) ? 1 : int'(clk_w);
      if ($urandom_range(0, 1) == 0) begin
        env_w = 32'((64'd1 << 32) / (2 * clk_e));
      end else begin
        env_w = $urandom();
      end
      load_regs(spb_w, clk_w, bar_w, ch_w, gain_w, $urandom(), env_w);
      tx_idle = (phase % 3 != 2);
      frames  = ((spb_w == 0) ? 1 : int'(spb_w)) * BEATS_PER_BAR
                * ((bar_w == 0) ? 1 : int'(bar_w));
      n   = frames + $urandom_range(0, 2);
      pos = 0;
      for (k = 0; k < n; k++) begin
        r = (k == 0) || ($urandom_range(0, 19) == 0);
        send_word(r);
        if (r) begin
          pos = 1;
          counted++;
        end else if (pos < frames) begin
          pos++;
          counted++;
        end
        if ($urandom_range(0, 49) == 0) begin
          settle(1'b0);
        end
      end
      phase++;
    end

    // Drain and give the verdict.
    settle(1'b0);
    repeat (50) @(posedge clk);
    if (fault_count == 0 && words_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/mcg_pkg.sv
rtl/metronome_click_generator.sv
tb/sv/click_checker.sv
tb/sv/tb_top.sv
